>>> hw/rtl/rmpt_pkg.sv
// ----------------------------------------------------------------------------
// rmpt_pkg
// Shared widths and the command and status bundles that pass between the
// controller and the datapath of the range maximum pair tree.
// ----------------------------------------------------------------------------
package rmpt_pkg;

    localparam int unsigned IDX_W   = 11;
    localparam int unsigned SCORE_W = 16;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned PAIR_W  = SCORE_W + TAG_W;

    // Commands from the controller, at most one of them active in a cycle.
    typedef struct packed {
        logic load;      // capture an accepted word
        logic clr;       // write zero at the sweep address and step it
        logic upd_leaf;  // write the leaf, read its sibling
        logic upd_step;  // write the parent maximum, read the next sibling
        logic q_rd_l;    // read the left border node if it is a right child
        logic q_rd_r;    // read the right border node, climb one level
        logic out_load;  // load the output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;  // sweep is at the last node
        logic leaf_ok;   // leaf index lies in 1..LEAVES
        logic p_gt1;     // current node has a parent
        logic p_gt3;     // parent of the current node has a parent
        logic l_lt_r;    // query walk not yet finished
    } t_status;

endpackage

>>> hw/rtl/rmpt_ram.sv
// ----------------------------------------------------------------------------
// rmpt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rmpt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> hw/rtl/rmpt_ctrl.sv
// ----------------------------------------------------------------------------
// rmpt_ctrl
// Sequencer for the tree: clearing sweep after reset, the leaf-to-root walk of
// an update, the two-reads-per-level walk of a query, and the output valid.
// ----------------------------------------------------------------------------
module rmpt_ctrl
    import rmpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_operation,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [5:0] {
        S_CLR   = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ULEAF = 6'b000100,
        S_USTEP = 6'b001000,
        S_QL    = 6'b010000,
        S_QR    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_operation ? S_QL : S_ULEAF;
                end
            end
            S_ULEAF: begin
                if (!i_status.leaf_ok) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.upd_leaf = 1'b1;
                    n_state        = i_status.p_gt1 ? S_USTEP : S_IDLE;
                end
            end
            S_USTEP: begin
                o_cmd.upd_step = 1'b1;
                n_state        = i_status.p_gt3 ? S_USTEP : S_IDLE;
            end
            S_QL: begin
                if (i_status.l_lt_r) begin
                    o_cmd.q_rd_l = 1'b1;
                    n_state      = S_QR;
                end else if (out_free) begin
                    // The pending right border read is folded into the result here.
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_QR: begin
                o_cmd.q_rd_r = 1'b1;
                n_state      = S_QL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hw/rtl/rmpt_dp.sv
// ----------------------------------------------------------------------------
// rmpt_dp
// Datapath of the tree: node store, node pointers, running maximum and the
// output register. Node p holds the maximum of nodes 2p and 2p+1; leaf i sits
// at node LEAVES+i-1.
// ----------------------------------------------------------------------------
module rmpt_dp
    import rmpt_pkg::*;
#(
    parameter int unsigned LEAVES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [IDX_W-1:0]   i_leaf_index,
    input  logic [SCORE_W-1:0] i_new_score,
    input  logic [TAG_W-1:0]   i_new_tag,
    input  logic [IDX_W-1:0]   i_range_low,
    input  logic [IDX_W-1:0]   i_range_high,
    output logic [SCORE_W-1:0] o_best_score,
    output logic [TAG_W-1:0]   o_best_tag
);

    localparam int unsigned DEPTH = 2 * LEAVES;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned TW    = AW + 1;
    localparam int unsigned IW    = ((TW > IDX_W) ? TW : IDX_W) + 1;

    // Update walk
    logic [AW-1:0]     r_p;
    logic [PAIR_W-1:0] r_cur;
    logic              r_leaf_ok;
    // Query walk
    logic [TW-1:0]     r_l, r_r;
    logic [PAIR_W-1:0] r_best;
    logic              r_pend;
    // Clearing sweep
    logic [AW-1:0]     r_clr_addr;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [PAIR_W-1:0] wdata, rdata;
    logic [PAIR_W-1:0] par_max, folded;
    logic [AW-1:0]     p_up;
    logic [IW-1:0]     leaf_x, lo_x, hi_x, lo_c, hi_c, node_x, l_x, r_x;
    logic              empty;
    logic [TW-1:0]     l_inc, r_dec;

    rmpt_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Packed as score then tag, so a plain unsigned compare is lexicographic.
    assign par_max = (r_cur > rdata) ? r_cur : rdata;
    assign folded  = (r_pend && (rdata > r_best)) ? rdata : r_best;
    assign p_up    = {1'b0, r_p[AW-1:1]};
    assign l_inc   = r_l + TW'(r_l[0]);
    assign r_dec   = r_r - TW'(1);

    // Window clipping at load time.
    assign leaf_x = IW'(i_leaf_index);
    assign node_x = IW'(LEAVES) + leaf_x - IW'(1);
    assign lo_x   = IW'(i_range_low);
    assign hi_x   = IW'(i_range_high);
    assign lo_c   = (lo_x == '0) ? IW'(1) : lo_x;
    assign hi_c   = (hi_x > IW'(LEAVES)) ? IW'(LEAVES) : hi_x;
    assign empty  = lo_c > hi_c;
    assign l_x    = IW'(LEAVES) + lo_c - IW'(1);
    assign r_x    = IW'(LEAVES) + hi_c;

    always_comb begin
        we    = 1'b0;
        waddr = r_p;
        wdata = r_cur;
        raddr = r_p ^ AW'(1);
        if (i_cmd.clr) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else if (i_cmd.upd_leaf) begin
            we = 1'b1;
        end else if (i_cmd.upd_step) begin
            we    = 1'b1;
            waddr = p_up;
            wdata = par_max;
            raddr = p_up ^ AW'(1);
        end else if (i_cmd.q_rd_l) begin
            raddr = r_l[AW-1:0];
        end else if (i_cmd.q_rd_r) begin
            raddr = r_dec[AW-1:0];
        end
    end

    assign o_status.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.leaf_ok  = r_leaf_ok;
    assign o_status.p_gt1    = (r_p > AW'(1));
    assign o_status.p_gt3    = (r_p > AW'(3));
    assign o_status.l_lt_r   = (r_l < r_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            // A border read issued last cycle lands in the running maximum now.
            r_pend <= (i_cmd.q_rd_l && r_l[0]) || (i_cmd.q_rd_r && r_r[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_leaf_ok <= (leaf_x != '0) && (leaf_x <= IW'(LEAVES));
            r_p       <= node_x[AW-1:0];
            r_cur     <= {i_new_score, i_new_tag};
            r_l       <= empty ? '0 : l_x[TW-1:0];
            r_r       <= empty ? '0 : r_x[TW-1:0];
            r_best    <= '0;
        end else begin
            r_best <= folded;
            if (i_cmd.upd_step) begin
                r_p   <= p_up;
                r_cur <= par_max;
            end
            if (i_cmd.q_rd_r) begin
                r_l <= {1'b0, l_inc[TW-1:1]};
                r_r <= {1'b0, r_r[TW-1:1]};
            end
        end
        if (i_cmd.out_load) begin
            o_best_score <= folded[PAIR_W-1:TAG_W];
            o_best_tag   <= folded[TAG_W-1:0];
        end
    end

endmodule

>>> hw/rtl/range_max_pair_tree.sv
// ----------------------------------------------------------------------------
// range_max_pair_tree
// Range maximum tree over LEAVES (score, tag) pairs with point updates.
//
//   Channel  Handshake          Words
//   input    i_valid / o_ready  i_operation, i_leaf_index, i_new_score,
//                               i_new_tag, i_range_low, i_range_high
//   output   o_valid / i_ready  o_best_score, o_best_tag (queries only)
//
// One word is worked on at a time through a single node RAM with one write and
// one read port. An update walks from the leaf to the root, one tree level at a
// time; a query needs two reads through the one read port for each of up to
// log2(LEAVES) + 1 levels, and an empty window needs no reads. After reset
// the RAM is swept to zero pairs with o_ready low. A held result stalls only
// a query that has finished its walk; updates are taken while it is held,
// but not while such a query waits.
// ----------------------------------------------------------------------------
module range_max_pair_tree
    import rmpt_pkg::*;
#(
    parameter int unsigned LEAVES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operation,
    input  logic [IDX_W-1:0]   i_leaf_index,
    input  logic [SCORE_W-1:0] i_new_score,
    input  logic [TAG_W-1:0]   i_new_tag,
    input  logic [IDX_W-1:0]   i_range_low,
    input  logic [IDX_W-1:0]   i_range_high,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SCORE_W-1:0] o_best_score,
    output logic [TAG_W-1:0]   o_best_tag
);

    t_cmd    cmd;
    t_status status;

    rmpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    rmpt_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_leaf_index (i_leaf_index),
        .i_new_score  (i_new_score),
        .i_new_tag    (i_new_tag),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_best_score (o_best_score),
        .o_best_tag   (o_best_tag)
    );

endmodule
